FILE: design/five_stage_pipelined_cpu8_macros.svh
// Assertion macros shared by the CPU block.
`ifndef FIVE_STAGE_PIPELINED_CPU8_MACROS_SVH
`define FIVE_STAGE_PIPELINED_CPU8_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSPC8_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FSPC8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/fspc8_pkg.sv
// Package: types, codes and helpers of the 8-bit pipelined CPU.
package fspc8_pkg;

  localparam int MEM_BYTES = 256;
  localparam int NUM_REGS  = 16;
  localparam int CNT_NUM   = 8;

  localparam logic [7:0] CLR_LAST = 8'(MEM_BYTES - 1);

  // item kinds
  localparam logic [2:0] KIND_LD_INSTR = 3'd0;
  localparam logic [2:0] KIND_LD_DATA  = 3'd1;
  localparam logic [2:0] KIND_LD_REG   = 3'd2;
  localparam logic [2:0] KIND_TICK     = 3'd3;
  localparam logic [2:0] KIND_RD_DATA  = 3'd4;
  localparam logic [2:0] KIND_RD_REG   = 3'd5;

  // opcodes
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_INC  = 4'd3;
  localparam logic [3:0] OP_AND  = 4'd4;
  localparam logic [3:0] OP_OR   = 4'd5;
  localparam logic [3:0] OP_NOT  = 4'd6;
  localparam logic [3:0] OP_XOR  = 4'd7;
  localparam logic [3:0] OP_LD   = 4'd8;
  localparam logic [3:0] OP_ST   = 4'd9;
  localparam logic [3:0] OP_JMP  = 4'd10;
  localparam logic [3:0] OP_BEQZ = 4'd11;
  localparam logic [3:0] OP_HALT = 4'd15;

  // statistics counter slots
  localparam int CNT_CYC    = 0;
  localparam int CNT_ARITH  = 1;
  localparam int CNT_LOGIC  = 2;
  localparam int CNT_DATA   = 3;
  localparam int CNT_CTRL   = 4;
  localparam int CNT_HALT   = 5;
  localparam int CNT_RAW    = 6;
  localparam int CNT_CSTALL = 7;

  typedef logic [CNT_NUM-1:0][31:0] cnt_arr_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CLEAR,
    PH_DISPATCH,
    PH_RD,
    PH_WB,
    PH_MEMRD,
    PH_MEM,
    PH_EX,
    PH_IDA,
    PH_IDB,
    PH_ID
  } phase_e;

  typedef struct packed {
    logic       accept;
    phase_e     phase;
    logic [7:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       halted;
  } sts_t;

  // saturating add of a small increment
  function automatic logic [31:0] sat_add(input logic [31:0] v, input logic [1:0] n);
    logic [32:0] s;
    s = {1'b0, v} + {31'd0, n};
    return s[32] ? '1 : s[31:0];
  endfunction

endpackage

FILE: design/fspc8_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fspc8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/fspc8_ctrl.sv
// Controller: sequences clearing, item dispatch and the stage phases of a tick.
module fspc8_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  fspc8_pkg::sts_t   sts_i,
  output fspc8_pkg::cmd_t   cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_RD,
    S_WB,
    S_MEMRD,
    S_MEM,
    S_EX,
    S_IDA,
    S_IDB,
    S_ID,
    S_DONE
  } state_e;

  state_e     state_q;
  logic [7:0] clr_q;
  logic       busy_q;
  logic       done_q;
  logic       accept;

  assign accept = start_i & ~busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 8'd1;
          if (clr_q == fspc8_pkg::CLR_LAST) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
          end
        end
        S_IDLE, S_DONE: begin
          done_q <= 1'b0;
          if (accept) begin
            state_q <= S_DISPATCH;
            busy_q  <= 1'b1;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_DISPATCH: begin
          if (sts_i.kind == fspc8_pkg::KIND_RD_DATA || sts_i.kind == fspc8_pkg::KIND_RD_REG)
          begin
            state_q <= S_RD;
          end else if (sts_i.kind == fspc8_pkg::KIND_TICK && !sts_i.halted) begin
            state_q <= S_WB;
          end else begin
            state_q <= S_DONE;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
          end
        end
        S_WB:    state_q <= S_MEMRD;
        S_MEMRD: state_q <= S_MEM;
        S_MEM:   state_q <= S_EX;
        S_EX:    state_q <= S_IDA;
        S_IDA:   state_q <= S_IDB;
        S_IDB:   state_q <= S_ID;
        S_RD, S_ID: begin
          state_q <= S_DONE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.accept   = accept;
    cmd_o.clr_addr = clr_q;
    case (state_q)
      S_CLEAR:    cmd_o.phase = fspc8_pkg::PH_CLEAR;
      S_DISPATCH: cmd_o.phase = fspc8_pkg::PH_DISPATCH;
      S_RD:       cmd_o.phase = fspc8_pkg::PH_RD;
      S_WB:       cmd_o.phase = fspc8_pkg::PH_WB;
      S_MEMRD:    cmd_o.phase = fspc8_pkg::PH_MEMRD;
      S_MEM:      cmd_o.phase = fspc8_pkg::PH_MEM;
      S_EX:       cmd_o.phase = fspc8_pkg::PH_EX;
      S_IDA:      cmd_o.phase = fspc8_pkg::PH_IDA;
      S_IDB:      cmd_o.phase = fspc8_pkg::PH_IDB;
      S_ID:       cmd_o.phase = fspc8_pkg::PH_ID;
      default:    cmd_o.phase = fspc8_pkg::PH_IDLE;
    endcase
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

FILE: design/fspc8_dp.sv
// Datapath: memories, register bank, pipeline latches, scoreboard and counters.
module fspc8_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fspc8_pkg::cmd_t     cmd_i,
  input  logic [2:0]          kind_i,
  input  logic [7:0]          address_i,
  input  logic [3:0]          reg_index_i,
  input  logic [7:0]          value_i,
  output fspc8_pkg::sts_t     sts_o,
  output logic [7:0]          read_value_o,
  output logic                halted_o,
  output fspc8_pkg::cnt_arr_t cnt_o
);

  // latched item
  logic [2:0] kind_q;
  logic [7:0] addr_q, val_q;
  logic [3:0] ri_q;

  // pipeline state
  logic [7:0]  fetch_pc_q, fetch_pc_d;
  logic        fetch_en_q, fetch_en_d;
  logic        dec_valid_q, dec_valid_d, dec_hold_q, dec_hold_d;
  logic [15:0] dec_ir_q, dec_ir_d;
  logic        ex_valid_q, ex_valid_d, ex_hold_q, ex_hold_d;
  logic [15:0] ex_ir_q, ex_ir_d;
  logic [7:0]  ex_pc_q, ex_pc_d, ex_a_q, ex_a_d, ex_b_q, ex_b_d;
  logic        mem_valid_q, mem_valid_d;
  logic [15:0] mem_ir_q, mem_ir_d;
  logic [7:0]  mem_ao_q, mem_ao_d;
  logic        wb_valid_q, wb_valid_d;
  logic [15:0] wb_ir_q, wb_ir_d;
  logic [7:0]  wb_ao_q, wb_ao_d, wb_lmd_q, wb_lmd_d;
  logic        halt_q, halt_d;
  logic [fspc8_pkg::NUM_REGS-1:0] busy_bits_q, busy_bits_d;
  fspc8_pkg::cnt_arr_t cnt_q, cnt_d;
  logic [7:0]  read_value_q, read_value_d;
  logic [7:0]  opa_q, opa_d, ir_hi_q, ir_hi_d;

  // RAM ports
  logic       i_we, i_re, d_we, d_re, r_we, r_re;
  logic [7:0] i_waddr, i_raddr, i_wdata, i_rdata;
  logic [7:0] d_waddr, d_raddr, d_wdata, d_rdata;
  logic [3:0] r_waddr, r_raddr;
  logic [7:0] r_wdata, r_rdata;

  // field decode
  logic [3:0] wb_op, wb_rd, mem_op, mem_rd, ex_op, id_op, id_d, id_s, id_t;
  logic [15:0] ex_mul;

  assign wb_op  = wb_ir_q[15:12];
  assign wb_rd  = wb_ir_q[11:8];
  assign mem_op = mem_ir_q[15:12];
  assign mem_rd = mem_ir_q[11:8];
  assign ex_op  = ex_ir_q[15:12];
  assign id_op  = dec_ir_q[15:12];
  assign id_d   = dec_ir_q[11:8];
  assign id_s   = dec_ir_q[7:4];
  assign id_t   = dec_ir_q[3:0];
  assign ex_mul = {8'd0, ex_a_q} * {8'd0, ex_b_q};

  fspc8_ram #(.WIDTH(8), .DEPTH(fspc8_pkg::MEM_BYTES)) u_imem (
    .clk_i, .we_i(i_we), .waddr_i(i_waddr), .wdata_i(i_wdata),
    .re_i(i_re), .raddr_i(i_raddr), .rdata_o(i_rdata)
  );

  fspc8_ram #(.WIDTH(8), .DEPTH(fspc8_pkg::MEM_BYTES)) u_dmem (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .re_i(d_re), .raddr_i(d_raddr), .rdata_o(d_rdata)
  );

  fspc8_ram #(.WIDTH(8), .DEPTH(fspc8_pkg::NUM_REGS)) u_regs (
    .clk_i, .we_i(r_we), .waddr_i(r_waddr), .wdata_i(r_wdata),
    .re_i(r_re), .raddr_i(r_raddr), .rdata_o(r_rdata)
  );

  always_comb begin
    fetch_pc_d   = fetch_pc_q;
    fetch_en_d   = fetch_en_q;
    dec_valid_d  = dec_valid_q;
    dec_hold_d   = dec_hold_q;
    dec_ir_d     = dec_ir_q;
    ex_valid_d   = ex_valid_q;
    ex_hold_d    = ex_hold_q;
    ex_ir_d      = ex_ir_q;
    ex_pc_d      = ex_pc_q;
    ex_a_d       = ex_a_q;
    ex_b_d       = ex_b_q;
    mem_valid_d  = mem_valid_q;
    mem_ir_d     = mem_ir_q;
    mem_ao_d     = mem_ao_q;
    wb_valid_d   = wb_valid_q;
    wb_ir_d      = wb_ir_q;
    wb_ao_d      = wb_ao_q;
    wb_lmd_d     = wb_lmd_q;
    halt_d       = halt_q;
    busy_bits_d  = busy_bits_q;
    cnt_d        = cnt_q;
    read_value_d = read_value_q;
    opa_d        = opa_q;
    ir_hi_d      = ir_hi_q;
    i_we = 1'b0; i_waddr = addr_q; i_wdata = val_q; i_re = 1'b0; i_raddr = fetch_pc_q;
    d_we = 1'b0; d_waddr = addr_q; d_wdata = val_q; d_re = 1'b0; d_raddr = addr_q;
    r_we = 1'b0; r_waddr = ri_q;   r_wdata = val_q; r_re = 1'b0; r_raddr = ri_q;

    case (cmd_i.phase)
      fspc8_pkg::PH_CLEAR: begin
        i_we = 1'b1; i_waddr = cmd_i.clr_addr; i_wdata = '0;
        d_we = 1'b1; d_waddr = cmd_i.clr_addr; d_wdata = '0;
        r_we = 1'b1; r_waddr = cmd_i.clr_addr[3:0]; r_wdata = '0;
      end

      fspc8_pkg::PH_DISPATCH: begin
        read_value_d = '0;
        case (kind_q)
          fspc8_pkg::KIND_LD_INSTR: i_we = 1'b1;
          fspc8_pkg::KIND_LD_DATA:  d_we = 1'b1;
          fspc8_pkg::KIND_LD_REG:   r_we = 1'b1;
          fspc8_pkg::KIND_RD_DATA:  d_re = 1'b1;
          fspc8_pkg::KIND_RD_REG:   r_re = 1'b1;
          default: ;
        endcase
      end

      fspc8_pkg::PH_RD: begin
        read_value_d = (kind_q == fspc8_pkg::KIND_RD_DATA) ? d_rdata : r_rdata;
      end

      fspc8_pkg::PH_WB: begin
        cnt_d[fspc8_pkg::CNT_CYC] = fspc8_pkg::sat_add(cnt_q[fspc8_pkg::CNT_CYC], 2'd1);
        // load data for MEM, ready next cycle
        d_re    = 1'b1;
        d_raddr = mem_ao_q;
        if (wb_valid_q) begin
          wb_valid_d = 1'b0;
          if (wb_op == fspc8_pkg::OP_HALT) begin
            halt_d = 1'b1;
          end else begin
            r_we    = (wb_rd != 4'd0);
            r_waddr = wb_rd;
            r_wdata = (wb_op == fspc8_pkg::OP_LD) ? wb_lmd_q : wb_ao_q;
            busy_bits_d[wb_rd] = 1'b0;
          end
        end
      end

      fspc8_pkg::PH_MEMRD: begin
        // store data, read after writeback
        r_re    = 1'b1;
        r_raddr = mem_rd;
      end

      fspc8_pkg::PH_MEM: begin
        if (mem_valid_q) begin
          mem_valid_d = 1'b0;
          case (mem_op)
            fspc8_pkg::OP_HALT: begin
              wb_valid_d = 1'b1;
              wb_ir_d    = mem_ir_q;
            end
            fspc8_pkg::OP_JMP, fspc8_pkg::OP_BEQZ: begin
              if (fetch_pc_q == mem_ao_q) begin
                dec_valid_d = 1'b0;
                dec_hold_d  = 1'b0;
                ex_hold_d   = 1'b0;
              end else begin
                // redirect and flush everything
                fetch_pc_d  = mem_ao_q;
                fetch_en_d  = 1'b1;
                dec_valid_d = 1'b0; dec_hold_d = 1'b0; dec_ir_d = '0;
                ex_valid_d  = 1'b0; ex_hold_d  = 1'b0; ex_ir_d  = '0;
                ex_pc_d     = '0;   ex_a_d     = '0;   ex_b_d   = '0;
                mem_ir_d    = '0;   mem_ao_d   = '0;
                wb_ir_d     = '0;   wb_ao_d    = '0;   wb_lmd_d = '0;
              end
              wb_valid_d = 1'b0;
            end
            fspc8_pkg::OP_ST: begin
              d_we       = 1'b1;
              d_waddr    = mem_ao_q;
              d_wdata    = r_rdata;
              wb_ao_d    = '0;
              wb_ir_d    = '0;
              wb_lmd_d   = '0;
              wb_valid_d = 1'b1;
            end
            fspc8_pkg::OP_LD: begin
              wb_lmd_d   = d_rdata;
              wb_ir_d    = mem_ir_q;
              wb_ao_d    = mem_ao_q;
              wb_valid_d = 1'b1;
            end
            default: begin
              wb_ao_d    = mem_ao_q;
              wb_ir_d    = mem_ir_q;
              wb_lmd_d   = '0;
              wb_valid_d = 1'b1;
            end
          endcase
        end
      end

      fspc8_pkg::PH_EX: begin
        if (ex_valid_q && !ex_hold_q) begin
          case (ex_op)
            fspc8_pkg::OP_ADD, fspc8_pkg::OP_SUB, fspc8_pkg::OP_MUL, fspc8_pkg::OP_INC:
              cnt_d[fspc8_pkg::CNT_ARITH] =
                fspc8_pkg::sat_add(cnt_q[fspc8_pkg::CNT_ARITH], 2'd1);
            fspc8_pkg::OP_AND, fspc8_pkg::OP_OR, fspc8_pkg::OP_NOT, fspc8_pkg::OP_XOR:
              cnt_d[fspc8_pkg::CNT_LOGIC] =
                fspc8_pkg::sat_add(cnt_q[fspc8_pkg::CNT_LOGIC], 2'd1);
            fspc8_pkg::OP_LD, fspc8_pkg::OP_ST:
              cnt_d[fspc8_pkg::CNT_DATA] =
                fspc8_pkg::sat_add(cnt_q[fspc8_pkg::CNT_DATA], 2'd1);
            fspc8_pkg::OP_JMP, fspc8_pkg::OP_BEQZ: begin
              cnt_d[fspc8_pkg::CNT_CTRL] =
                fspc8_pkg::sat_add(cnt_q[fspc8_pkg::CNT_CTRL], 2'd1);
              ex_hold_d = 1'b1;
            end
            default: ;
          endcase
          case (ex_op)
            fspc8_pkg::OP_ADD: mem_ao_d = ex_a_q + ex_b_q;
            fspc8_pkg::OP_SUB: mem_ao_d = ex_a_q - ex_b_q;
            fspc8_pkg::OP_MUL: mem_ao_d = ex_mul[7:0];
            fspc8_pkg::OP_INC: mem_ao_d = ex_a_q + 8'd1;
            fspc8_pkg::OP_AND: mem_ao_d = ex_a_q & ex_b_q;
            fspc8_pkg::OP_OR:  mem_ao_d = ex_a_q | ex_b_q;
            fspc8_pkg::OP_NOT: mem_ao_d = ~ex_a_q;
            fspc8_pkg::OP_XOR: mem_ao_d = ex_a_q ^ ex_b_q;
            fspc8_pkg::OP_LD, fspc8_pkg::OP_ST: mem_ao_d = ex_a_q + ex_b_q;
            fspc8_pkg::OP_JMP: mem_ao_d = ex_pc_q + {ex_a_q[6:0], 1'b0};
            fspc8_pkg::OP_BEQZ:
              mem_ao_d = (ex_a_q == 8'd0) ? ex_pc_q + {ex_b_q[6:0], 1'b0} : ex_pc_q;
            default: ; // ALU latch keeps its value
          endcase
          mem_ir_d    = ex_ir_q;
          mem_valid_d = 1'b1;
          ex_valid_d  = 1'b0;
        end
      end

      fspc8_pkg::PH_IDA: begin
        r_re    = 1'b1;
        r_raddr = (id_op == fspc8_pkg::OP_BEQZ || id_op == fspc8_pkg::OP_INC) ? id_d : id_s;
        i_re    = 1'b1;
        i_raddr = fetch_pc_q;
      end

      fspc8_pkg::PH_IDB: begin
        opa_d   = r_rdata;
        r_re    = 1'b1;
        r_raddr = id_t;
        ir_hi_d = i_rdata;
        i_re    = 1'b1;
        i_raddr = fetch_pc_q + 8'd1;
      end

      fspc8_pkg::PH_ID: begin
        // decode
        if (dec_valid_q && !dec_hold_q && !ex_valid_q && !ex_hold_q) begin
          ex_ir_d = dec_ir_q;
          case (id_op)
            fspc8_pkg::OP_HALT: begin
              fetch_en_d  = 1'b0;
              dec_valid_d = 1'b0;
              ex_valid_d  = 1'b1;
              cnt_d[fspc8_pkg::CNT_HALT] =
                fspc8_pkg::sat_add(cnt_q[fspc8_pkg::CNT_HALT], 2'd1);
            end
            fspc8_pkg::OP_JMP: begin
              dec_valid_d = 1'b0;
              ex_valid_d  = 1'b1;
              dec_hold_d  = 1'b1;
              ex_a_d      = dec_ir_q[11:4];
              ex_pc_d     = fetch_pc_q;
              cnt_d[fspc8_pkg::CNT_CSTALL] =
                fspc8_pkg::sat_add(cnt_q[fspc8_pkg::CNT_CSTALL], 2'd2);
            end
            default: begin
              if ((id_op == fspc8_pkg::OP_BEQZ || id_op == fspc8_pkg::OP_INC)
                  ? busy_bits_q[id_d]
                  : (id_op == fspc8_pkg::OP_LD || id_op == fspc8_pkg::OP_ST ||
                     id_op == fspc8_pkg::OP_NOT)
                    ? busy_bits_q[id_s]
                    : (busy_bits_q[id_s] | busy_bits_q[id_t])) begin
                // source still in flight
                cnt_d[fspc8_pkg::CNT_RAW] =
                  fspc8_pkg::sat_add(cnt_q[fspc8_pkg::CNT_RAW], 2'd1);
                ex_valid_d  = 1'b0;
                dec_valid_d = 1'b1;
              end else begin
                dec_valid_d = 1'b0;
                ex_valid_d  = 1'b1;
                ex_a_d      = opa_q;
                case (id_op)
                  fspc8_pkg::OP_BEQZ: begin
                    dec_hold_d = 1'b1;
                    ex_pc_d    = fetch_pc_q;
                    ex_b_d     = dec_ir_q[7:0];
                    cnt_d[fspc8_pkg::CNT_CSTALL] =
                      fspc8_pkg::sat_add(cnt_q[fspc8_pkg::CNT_CSTALL], 2'd2);
                  end
                  fspc8_pkg::OP_ST: ex_b_d = {4'd0, id_t};
                  fspc8_pkg::OP_LD: begin
                    ex_b_d            = {4'd0, id_t};
                    busy_bits_d[id_d] = 1'b1;
                  end
                  fspc8_pkg::OP_INC, fspc8_pkg::OP_NOT: busy_bits_d[id_d] = 1'b1;
                  default: begin
                    ex_b_d            = r_rdata;
                    busy_bits_d[id_d] = 1'b1;
                  end
                endcase
              end
            end
          endcase
        end
        // fetch
        if (fetch_en_d && !dec_valid_d && !dec_hold_d) begin
          dec_ir_d    = {ir_hi_q, i_rdata};
          dec_valid_d = 1'b1;
          fetch_pc_d  = fetch_pc_q + 8'd2;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_pc_q   <= '0;
      fetch_en_q   <= 1'b1;
      dec_valid_q  <= 1'b0;
      dec_hold_q   <= 1'b0;
      dec_ir_q     <= '0;
      ex_valid_q   <= 1'b0;
      ex_hold_q    <= 1'b0;
      ex_ir_q      <= '0;
      ex_pc_q      <= '0;
      ex_a_q       <= '0;
      ex_b_q       <= '0;
      mem_valid_q  <= 1'b0;
      mem_ir_q     <= '0;
      mem_ao_q     <= '0;
      wb_valid_q   <= 1'b0;
      wb_ir_q      <= '0;
      wb_ao_q      <= '0;
      wb_lmd_q     <= '0;
      halt_q       <= 1'b0;
      busy_bits_q  <= '0;
      cnt_q        <= '0;
      read_value_q <= '0;
    end else begin
      fetch_pc_q   <= fetch_pc_d;
      fetch_en_q   <= fetch_en_d;
      dec_valid_q  <= dec_valid_d;
      dec_hold_q   <= dec_hold_d;
      dec_ir_q     <= dec_ir_d;
      ex_valid_q   <= ex_valid_d;
      ex_hold_q    <= ex_hold_d;
      ex_ir_q      <= ex_ir_d;
      ex_pc_q      <= ex_pc_d;
      ex_a_q       <= ex_a_d;
      ex_b_q       <= ex_b_d;
      mem_valid_q  <= mem_valid_d;
      mem_ir_q     <= mem_ir_d;
      mem_ao_q     <= mem_ao_d;
      wb_valid_q   <= wb_valid_d;
      wb_ir_q      <= wb_ir_d;
      wb_ao_q      <= wb_ao_d;
      wb_lmd_q     <= wb_lmd_d;
      halt_q       <= halt_d;
      busy_bits_q  <= busy_bits_d;
      cnt_q        <= cnt_d;
      read_value_q <= read_value_d;
    end
  end

  // item latch and operand scratch, no reset needed
  always_ff @(posedge clk_i) begin
    opa_q   <= opa_d;
    ir_hi_q <= ir_hi_d;
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      addr_q <= address_i;
      ri_q   <= reg_index_i;
      val_q  <= value_i;
    end
  end

  assign sts_o.kind   = kind_q;
  assign sts_o.halted = halt_q;
  assign read_value_o = read_value_q;
  assign halted_o     = halt_q;
  assign cnt_o        = cnt_q;

endmodule

FILE: design/five_stage_pipelined_cpu8.sv
// Top level of the 8-bit five-stage pipelined CPU with scoreboard.
//
// Usage: an item (kind, address, reg_index, value) is taken when start_i is
// high and busy_o is low. Exactly one result beat follows per item, shown
// for a single cycle with done_o high; the receiver cannot stall it.
// Kinds: load instruction byte, load data byte, load register, tick,
// read data byte, read register; the other two codes do nothing.
// Controller states from accept to done_o:
//   loads and undefined kinds : dispatch
//   reads                     : dispatch, then the registered read
//   tick (running)            : dispatch, then one state per stage step
//                               (WB, MEM read, MEM, EX, two register and
//                               instruction reads, ID+IF) since the register
//                               bank and memories have one read port each
//   tick (halted)             : dispatch
// A new item may be accepted in the cycle done_o is high.
// Reset: the instruction, data and register memories are swept to zero,
// one address per cycle over the whole address range; busy_o stays high meanwhile.
// Counters and the halt flag are always live on the result ports.
module five_stage_pipelined_cpu8 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  address_i,
  input  logic [3:0]  reg_index_i,
  input  logic [7:0]  value_i,
  output logic        done_o,
  output logic [7:0]  read_value_o,
  output logic        halted_o,
  output logic [31:0] cycle_count_o,
  output logic [31:0] arith_count_o,
  output logic [31:0] logic_count_o,
  output logic [31:0] data_count_o,
  output logic [31:0] control_count_o,
  output logic [31:0] halt_count_o,
  output logic [31:0] raw_stall_count_o,
  output logic [31:0] control_stall_count_o
);

`include "five_stage_pipelined_cpu8_macros.svh"

  fspc8_pkg::cmd_t     cmd;
  fspc8_pkg::sts_t     sts;
  fspc8_pkg::cnt_arr_t cnt;

  // sequencer
  fspc8_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i,
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o,
    .done_o
  );

  // pipeline state, memories and statistics
  fspc8_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i        (cmd),
    .kind_i,
    .address_i,
    .reg_index_i,
    .value_i,
    .sts_o        (sts),
    .read_value_o,
    .halted_o,
    .cnt_o        (cnt)
  );

  assign cycle_count_o         = cnt[fspc8_pkg::CNT_CYC];
  assign arith_count_o         = cnt[fspc8_pkg::CNT_ARITH];
  assign logic_count_o         = cnt[fspc8_pkg::CNT_LOGIC];
  assign data_count_o          = cnt[fspc8_pkg::CNT_DATA];
  assign control_count_o       = cnt[fspc8_pkg::CNT_CTRL];
  assign halt_count_o          = cnt[fspc8_pkg::CNT_HALT];
  assign raw_stall_count_o     = cnt[fspc8_pkg::CNT_RAW];
  assign control_stall_count_o = cnt[fspc8_pkg::CNT_CSTALL];

  // result beat only while idle for new work
  `FSPC8_ASSERT_NOW(a_done_not_busy, clk_i, rst_ni, done_o, !busy_o)
  // every accepted item occupies the block next cycle
  `FSPC8_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o && !done_o)
  // one beat per item
  `FSPC8_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  // halt is sticky
  `FSPC8_ASSERT_NEXT(a_halt_sticky, clk_i, rst_ni, halted_o, halted_o)

endmodule

FILE: tb/tb.sv
// Self-checking bench for the 8-bit five-stage pipelined CPU with scoreboard.
`timescale 1ns / 1ps

module tb;

  // kinds the block must ignore
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  localparam int DIR_ROWS = 25;
  localparam int RAND_ITEMS = 800;

  // one directed row; typed marks a read value that can be read off at a glance
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] addr;
    logic [3:0] ri;
    logic [7:0] val;
    logic       typed;
    logic [7:0] rd;
  } dir_row_t;

  // what one result beat must carry
  typedef struct {
    logic [7:0]  rd;
    logic        halted;
    logic [31:0] cnt [fspc8_pkg::CNT_NUM];
  } outcome_t;

  typedef struct packed { logic valid; logic hold; logic [15:0] ir; } dec_t;
  typedef struct packed {
    logic valid; logic hold; logic [15:0] ir; logic [7:0] pc; logic [7:0] a; logic [7:0] b;
  } exe_t;
  typedef struct packed { logic valid; logic [15:0] ir; logic [7:0] ao; } mem_t;
  typedef struct packed { logic valid; logic [15:0] ir; logic [7:0] ao; logic [7:0] lmd; } wb_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [2:0]  kind_i = '0;
  logic [7:0]  address_i = '0;
  logic [3:0]  reg_index_i = '0;
  logic [7:0]  value_i = '0;
  logic        done_o;
  logic [7:0]  read_value_o;
  logic        halted_o;
  logic [31:0] cycle_count_o, arith_count_o, logic_count_o, data_count_o;
  logic [31:0] control_count_o, halt_count_o, raw_stall_count_o, control_stall_count_o;

  five_stage_pipelined_cpu8 dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .kind_i, .address_i, .reg_index_i, .value_i,
    .done_o, .read_value_o, .halted_o, .cycle_count_o, .arith_count_o, .logic_count_o,
    .data_count_o, .control_count_o, .halt_count_o, .raw_stall_count_o,
    .control_stall_count_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow CPU: memories, scoreboard, stage latches and statistics
  // ---------------------------------------------------------------------------
  logic [7:0]  imem [fspc8_pkg::MEM_BYTES];
  logic [7:0]  dmem [fspc8_pkg::MEM_BYTES];
  logic [7:0]  regs [fspc8_pkg::NUM_REGS];
  logic        busy_bit [fspc8_pkg::NUM_REGS];
  logic [7:0]  pc_p;
  logic        fetch_on;
  dec_t        dec_p;
  exe_t        exe_p;
  mem_t        mem_p;
  wb_t         wb_p;
  logic        halted_p;
  logic [31:0] stats [fspc8_pkg::CNT_NUM];

  outcome_t    pending_q [$];
  int          mismatches = 0;
  int          idle_pct = 0;

  function automatic void bump(int idx, logic [31:0] n);
    stats[idx] = (stats[idx] > 32'hFFFF_FFFF - n) ? 32'hFFFF_FFFF : stats[idx] + n;
  endfunction

  function automatic void flush_pipe();
    fetch_on = 1'b1;
    dec_p = '0;
    exe_p = '0;
    mem_p = '0;
    wb_p  = '0;
  endfunction

  function automatic void step_wb();
    logic [3:0] op, d;
    if (!wb_p.valid) return;
    op = wb_p.ir[15:12];
    d  = wb_p.ir[11:8];
    wb_p.valid = 1'b0;
    if (op == fspc8_pkg::OP_HALT) begin
      halted_p = 1'b1;
      return;
    end
    if (d != 4'd0) regs[d] = (op == fspc8_pkg::OP_LD) ? wb_p.lmd : wb_p.ao;
    busy_bit[d] = 1'b0;
  endfunction

  function automatic void step_mem();
    logic [3:0] op, d;
    if (!mem_p.valid) return;
    mem_p.valid = 1'b0;
    op = mem_p.ir[15:12];
    d  = mem_p.ir[11:8];
    if (op == fspc8_pkg::OP_HALT) begin
      wb_p.valid = 1'b1;
      wb_p.ir = mem_p.ir;
    end else if (op == fspc8_pkg::OP_JMP || op == fspc8_pkg::OP_BEQZ) begin
      // branch resolved: release the holds, or redirect and flush
      if (pc_p == mem_p.ao) begin
        dec_p.valid = 1'b0;
        dec_p.hold  = 1'b0;
        exe_p.hold  = 1'b0;
      end else begin
        pc_p = mem_p.ao;
        flush_pipe();
      end
      wb_p.valid = 1'b0;
    end else if (op == fspc8_pkg::OP_ST) begin
      dmem[mem_p.ao] = regs[d];
      wb_p = '{valid: 1'b1, ir: '0, ao: '0, lmd: '0};
    end else if (op == fspc8_pkg::OP_LD) begin
      wb_p = '{valid: 1'b1, ir: mem_p.ir, ao: mem_p.ao, lmd: dmem[mem_p.ao]};
    end else begin
      wb_p = '{valid: 1'b1, ir: mem_p.ir, ao: mem_p.ao, lmd: '0};
    end
  endfunction

  function automatic void step_ex();
    logic [3:0] op;
    logic [7:0] a, b, ao;
    if (!exe_p.valid || exe_p.hold) return;
    op = exe_p.ir[15:12];
    a  = exe_p.a;
    b  = exe_p.b;
    ao = mem_p.ao;   // undefined opcodes leave the latch as it stands
    case (op)
      fspc8_pkg::OP_ADD: begin ao = a + b;    bump(fspc8_pkg::CNT_ARITH, 1); end
      fspc8_pkg::OP_SUB: begin ao = a - b;    bump(fspc8_pkg::CNT_ARITH, 1); end
      fspc8_pkg::OP_MUL: begin ao = a * b;    bump(fspc8_pkg::CNT_ARITH, 1); end
      fspc8_pkg::OP_INC: begin ao = a + 8'd1; bump(fspc8_pkg::CNT_ARITH, 1); end
      fspc8_pkg::OP_AND: begin ao = a & b;    bump(fspc8_pkg::CNT_LOGIC, 1); end
      fspc8_pkg::OP_OR:  begin ao = a | b;    bump(fspc8_pkg::CNT_LOGIC, 1); end
      fspc8_pkg::OP_NOT: begin ao = ~a;       bump(fspc8_pkg::CNT_LOGIC, 1); end
      fspc8_pkg::OP_XOR: begin ao = a ^ b;    bump(fspc8_pkg::CNT_LOGIC, 1); end
      fspc8_pkg::OP_LD, fspc8_pkg::OP_ST: begin
        ao = a + b;
        bump(fspc8_pkg::CNT_DATA, 1);
      end
      fspc8_pkg::OP_JMP: begin
        exe_p.hold = 1'b1;
        bump(fspc8_pkg::CNT_CTRL, 1);
        ao = exe_p.pc + {a[6:0], 1'b0};
      end
      fspc8_pkg::OP_BEQZ: begin
        exe_p.hold = 1'b1;
        bump(fspc8_pkg::CNT_CTRL, 1);
        ao = (a == 8'd0) ? exe_p.pc + {b[6:0], 1'b0} : exe_p.pc;
      end
      default: ;
    endcase
    mem_p.ao = ao;
    mem_p.ir = exe_p.ir;
    mem_p.valid = 1'b1;
    exe_p.valid = 1'b0;
  endfunction

  // scoreboard check; on a hazard decode keeps its word and execute stays empty
  function automatic logic raw_hold(logic hazard);
    if (!hazard) return 1'b0;
    bump(fspc8_pkg::CNT_RAW, 1);
    exe_p.valid = 1'b0;
    dec_p.valid = 1'b1;
    return 1'b1;
  endfunction

  function automatic void step_id();
    logic [15:0] ir;
    logic [3:0]  op, d, s, t;
    if (!dec_p.valid || dec_p.hold) return;
    if (exe_p.valid || exe_p.hold) return;
    ir = dec_p.ir;
    exe_p.ir = ir;
    op = ir[15:12];
    d  = ir[11:8];
    s  = ir[7:4];
    t  = ir[3:0];
    if (op == fspc8_pkg::OP_HALT) begin
      fetch_on = 1'b0;
      dec_p.valid = 1'b0;
      exe_p.valid = 1'b1;
      bump(fspc8_pkg::CNT_HALT, 1);
      return;
    end
    dec_p.valid = 1'b0;
    exe_p.valid = 1'b1;
    case (op)
      fspc8_pkg::OP_JMP: begin
        dec_p.hold = 1'b1;
        exe_p.a = ir[11:4];
        exe_p.pc = pc_p;
        bump(fspc8_pkg::CNT_CSTALL, 2);
      end
      fspc8_pkg::OP_BEQZ: begin
        if (raw_hold(busy_bit[d])) return;
        dec_p.hold = 1'b1;
        bump(fspc8_pkg::CNT_CSTALL, 2);
        exe_p.pc = pc_p;
        exe_p.a = regs[d];
        exe_p.b = ir[7:0];
      end
      fspc8_pkg::OP_LD, fspc8_pkg::OP_ST: begin
        if (raw_hold(busy_bit[s])) return;
        exe_p.a = regs[s];
        exe_p.b = {4'd0, t};
        if (op == fspc8_pkg::OP_LD) busy_bit[d] = 1'b1;
      end
      fspc8_pkg::OP_INC: begin
        if (raw_hold(busy_bit[d])) return;
        exe_p.a = regs[d];
        busy_bit[d] = 1'b1;
      end
      fspc8_pkg::OP_NOT: begin
        if (raw_hold(busy_bit[s])) return;
        exe_p.a = regs[s];
        busy_bit[d] = 1'b1;
      end
      default: begin
        if (raw_hold(busy_bit[s] || busy_bit[t])) return;
        exe_p.a = regs[s];
        exe_p.b = regs[t];
        busy_bit[d] = 1'b1;
      end
    endcase
  endfunction

  function automatic void step_if();
    if (!fetch_on) return;
    if (dec_p.valid || dec_p.hold) return;
    dec_p.ir = {imem[pc_p], imem[8'(pc_p + 8'd1)]};
    dec_p.valid = 1'b1;
    pc_p = pc_p + 8'd2;
  endfunction

  function automatic outcome_t run_item(logic [2:0] kind, logic [7:0] addr,
                                        logic [3:0] ri, logic [7:0] val);
    outcome_t o;
    o.rd = '0;
    case (kind)
      fspc8_pkg::KIND_LD_INSTR: imem[addr] = val;
      fspc8_pkg::KIND_LD_DATA:  dmem[addr] = val;
      fspc8_pkg::KIND_LD_REG:   regs[ri] = val;    // register zero too
      fspc8_pkg::KIND_TICK: begin
        if (!halted_p) begin
          bump(fspc8_pkg::CNT_CYC, 1);
          step_wb();
          step_mem();
          step_ex();
          step_id();
          step_if();
        end
      end
      fspc8_pkg::KIND_RD_DATA:  o.rd = dmem[addr];
      fspc8_pkg::KIND_RD_REG:   o.rd = regs[ri];
      default: ;
    endcase
    o.halted = halted_p;
    foreach (stats[i]) o.cnt[i] = stats[i];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every done_o beat against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void note_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected %0h, got %0h at %0t", name, want, got, $realtime);
    end
  endfunction

  always @(posedge clk_i) begin
    outcome_t    w;
    logic [31:0] got [fspc8_pkg::CNT_NUM];
    string       names [fspc8_pkg::CNT_NUM];
    if (rst_ni && done_o === 1'b1) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH: result beat with nothing expected");
      end else begin
        w = pending_q.pop_front();
        got = '{cycle_count_o, arith_count_o, logic_count_o, data_count_o,
                control_count_o, halt_count_o, raw_stall_count_o, control_stall_count_o};
        names = '{"cycle_count", "arith_count", "logic_count", "data_count",
                  "control_count", "halt_count", "raw_stall_count", "control_stall_count"};
        note_field("read_value", {24'd0, w.rd}, {24'd0, read_value_o});
        note_field("halted", {31'd0, w.halted}, {31'd0, halted_o});
        foreach (got[i]) note_field(names[i], w.cnt[i], got[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Offer one beat and hold start_i until it is taken. start_i is left high on
  // return so back-to-back beats never see a low-high pair in one time step.
  task automatic send(logic [2:0] kind, logic [7:0] addr, logic [3:0] ri, logic [7:0] val,
                      logic typed = 1'b0, logic [7:0] typed_rd = '0);
    outcome_t o;
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    kind_i      <= kind;
    address_i   <= addr;
    reg_index_i <= ri;
    value_i     <= val;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    o = run_item(kind, addr, ri, val);
    if (typed) o.rd = typed_rd;
    pending_q.push_back(o);
  endtask

  // random instruction word; never HALT, which would end the run for good
  function automatic logic [15:0] rand_word();
    logic [3:0] op;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)       op = 4'($urandom_range(12, 14));   // undefined opcodes
    else if (pick < 20) op = $urandom_range(0, 1) ? fspc8_pkg::OP_JMP : fspc8_pkg::OP_BEQZ;
    else                op = 4'($urandom_range(0, 9));
    return {op, 12'($urandom())};
  endfunction

  // directed rows: reset contents, extremes, register zero, spare kinds and a
  // short program with a RAW hazard on r1
  localparam dir_row_t DIR [DIR_ROWS] = '{
    '{fspc8_pkg::KIND_RD_DATA,  8'd0,   4'd0,  8'd0,   1'b1, 8'h00},
    '{fspc8_pkg::KIND_RD_REG,   8'd0,   4'd0,  8'd0,   1'b1, 8'h00},
    '{fspc8_pkg::KIND_LD_REG,   8'd0,   4'd15, 8'hFF,  1'b1, 8'h00},
    '{fspc8_pkg::KIND_RD_REG,   8'd0,   4'd15, 8'd0,   1'b1, 8'hFF},
    '{fspc8_pkg::KIND_LD_DATA,  8'd255, 4'd0,  8'hFF,  1'b1, 8'h00},
    '{fspc8_pkg::KIND_RD_DATA,  8'd255, 4'd0,  8'd0,   1'b1, 8'hFF},
    '{KIND_SPARE_LO,            8'd255, 4'd15, 8'hFF,  1'b1, 8'h00},
    '{KIND_SPARE_HI,            8'd255, 4'd15, 8'hFF,  1'b1, 8'h00},
    '{fspc8_pkg::KIND_LD_REG,   8'd0,   4'd0,  8'h5A,  1'b1, 8'h00},
    '{fspc8_pkg::KIND_RD_REG,   8'd0,   4'd0,  8'd0,   1'b1, 8'h5A},
    '{fspc8_pkg::KIND_LD_INSTR, 8'd0,   4'd0,  8'h21,  1'b1, 8'h00},   // MUL r1 = r15 * r15
    '{fspc8_pkg::KIND_LD_INSTR, 8'd1,   4'd0,  8'hFF,  1'b1, 8'h00},
    '{fspc8_pkg::KIND_LD_INSTR, 8'd2,   4'd0,  8'h33,  1'b1, 8'h00},   // INC r3
    '{fspc8_pkg::KIND_LD_INSTR, 8'd3,   4'd0,  8'h00,  1'b1, 8'h00},
    '{fspc8_pkg::KIND_LD_INSTR, 8'd4,   4'd0,  8'h04,  1'b1, 8'h00},   // ADD r4 = r1 + r0
    '{fspc8_pkg::KIND_LD_INSTR, 8'd5,   4'd0,  8'h10,  1'b1, 8'h00},
    '{fspc8_pkg::KIND_TICK,     8'd0,   4'd0,  8'd0,   1'b0, 8'h00},
    '{fspc8_pkg::KIND_TICK,     8'd0,   4'd0,  8'd0,   1'b0, 8'h00},
    '{fspc8_pkg::KIND_TICK,     8'd0,   4'd0,  8'd0,   1'b0, 8'h00},
    '{fspc8_pkg::KIND_TICK,     8'd0,   4'd0,  8'd0,   1'b0, 8'h00},
    '{fspc8_pkg::KIND_TICK,     8'd0,   4'd0,  8'd0,   1'b0, 8'h00},
    '{fspc8_pkg::KIND_TICK,     8'd0,   4'd0,  8'd0,   1'b0, 8'h00},
    '{fspc8_pkg::KIND_TICK,     8'd0,   4'd0,  8'd0,   1'b0, 8'h00},
    '{fspc8_pkg::KIND_RD_REG,   8'd0,   4'd4,  8'd0,   1'b0, 8'h00},
    '{fspc8_pkg::KIND_RD_REG,   8'd0,   4'd1,  8'd0,   1'b0, 8'h00}
  };

  initial begin
    logic [15:0] word;
    logic [7:0]  base;
    int          items, burst, seg, guard;

    foreach (imem[i]) begin
      imem[i] = '0;
      dmem[i] = '0;
    end
    foreach (regs[i]) begin
      regs[i] = '0;
      busy_bit[i] = 1'b0;
    end
    foreach (stats[i]) stats[i] = '0;
    pc_p = '0;
    halted_p = 1'b0;
    flush_pipe();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR[i])
      send(DIR[i].kind, DIR[i].addr, DIR[i].ri, DIR[i].val, DIR[i].typed, DIR[i].rd);

    // Random part. Sender idling rotates: none, 66 in 100, 16 in 100.
    items = 0;
    while (items < RAND_ITEMS) begin
      case ((items / 100) % 3)
        0: idle_pct = 0;
        1: idle_pct = 66;
        default: idle_pct = 16;
      endcase
      if (items >= 400 && items < 410 && pending_q.size() != 0) begin
        // drain: hold off until every outstanding beat is back
        start_i <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
      end
      seg = $urandom_range(0, 9);
      if (seg <= 2) begin
        // patch a few words just ahead of fetch so they actually run
        base = pc_p + 8'(2 * $urandom_range(0, 6));
        burst = $urandom_range(1, 4);
        for (int k = 0; k < burst; k++) begin
          word = rand_word();
          send(fspc8_pkg::KIND_LD_INSTR, base, 4'($urandom()), word[15:8]);
          send(fspc8_pkg::KIND_LD_INSTR, base + 8'd1, 4'($urandom()), word[7:0]);
          base = base + 8'd2;
          items += 2;
        end
      end else if (seg == 3) begin
        send(fspc8_pkg::KIND_LD_DATA, 8'($urandom()), 4'($urandom()), 8'($urandom()));
        items++;
      end else if (seg == 4) begin
        send(fspc8_pkg::KIND_LD_REG, 8'($urandom()), 4'($urandom()), 8'($urandom()));
        items++;
      end else if (seg <= 7) begin
        burst = $urandom_range(1, 12);
        repeat (burst)
          send(fspc8_pkg::KIND_TICK, 8'($urandom()), 4'($urandom()), 8'($urandom()));
        items += burst;
      end else if (seg == 8) begin
        send($urandom_range(0, 1) ? fspc8_pkg::KIND_RD_DATA : fspc8_pkg::KIND_RD_REG,
             8'($urandom()), 4'($urandom()), 8'($urandom()));
        items++;
      end else begin
        // any kind with random fields, HALT words excluded
        word[2:0] = 3'($urandom());
        word[15:8] = 8'($urandom());
        if (word[2:0] == fspc8_pkg::KIND_LD_INSTR && word[15:12] == fspc8_pkg::OP_HALT)
          word[15:12] = fspc8_pkg::OP_XOR;
        send(word[2:0], 8'($urandom()), 4'($urandom()), word[15:8]);
        items++;
      end
    end

    // Ending: HALT everywhere fetch can land, then tick until it retires
    idle_pct = 16;
    for (int a = 0; a < fspc8_pkg::MEM_BYTES; a += 2)
      send(fspc8_pkg::KIND_LD_INSTR, 8'(a), 4'($urandom()),
           {fspc8_pkg::OP_HALT, 4'($urandom())});
    guard = 0;
    while (!halted_p && guard < 400) begin
      send(fspc8_pkg::KIND_TICK, 8'($urandom()), 4'($urandom()), 8'($urandom()));
      guard++;
    end
    repeat (6) send(fspc8_pkg::KIND_TICK, 8'($urandom()), 4'($urandom()), 8'($urandom()));
    for (int r = 0; r < fspc8_pkg::NUM_REGS; r++)
      send(fspc8_pkg::KIND_RD_REG, 8'd0, 4'(r), 8'd0);
    send(fspc8_pkg::KIND_RD_DATA, 8'($urandom()), 4'd0, 8'd0);

    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);   // catch any stray beat
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog: many times the reset sweep plus ~1400 beats at worst-case gap and latency
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
